FILE: rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion, also checked during reset
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: rtl/irt_pkg.sv
// constants and types of the interval range table
package irt_pkg;

    localparam int DEPTH   = 64;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 8;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int FILL_W  = $clog2(DEPTH + 3);
    localparam int MEM_AW  = IDX_W + 1;

    localparam int KB_LSB = 0;
    localparam int KE_LSB = KEY_W;
    localparam int NV_LSB = 2 * KEY_W;
    localparam int PK_LSB = 2 * KEY_W + VAL_W;

    localparam int S_FIELDS_W = 3 * KEY_W + VAL_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = VAL_W + COUNT_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int RV_LSB  = 0;
    localparam int CNT_LSB = VAL_W;
    localparam int OVF_BIT = VAL_W + COUNT_W;

    typedef enum logic [0:0] {
        OP_ASSIGN = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

FILE: rtl/interval_range_table_unit.sv
// interval range table: sorted boundary table with range assign and key lookup
//
// requests arrive on the s_ channel: s_tuser carries the op (assign or lookup),
// s_tdata carries key_begin, key_end, new_value and probe_key. every request
// gives one response on the m_ channel with read_value, entry_count, overflow.
// the user must write default_value through cfg_we / cfg_wdata only while the
// block is idle; the block itself does not enforce it. the table lives in one
// memory split into two banks; a request scans the current bank entry by entry
// (registered memory read, then compare) and an assign writes the rebuilt
// table into the other bank, which becomes current unless the result would not
// fit. an assign with an empty interval goes straight to the response.
// s_tready is high only while idle, which starts the cycle after the response
// is loaded, so a request is not taken until the last response is loaded.
// the response sits in an output register: a stalled receiver holds it there
// and the block may take the next request meanwhile, finishing that one when
// the output register frees up. reset (aresetn low, synchronous) empties the
// table, clears default_value and drops any pending response; memory contents
// need no clearing since only entries below the count are read.
module interval_range_table_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [irt_pkg::VAL_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key_begin, key_end, new_value, probe_key
    input  logic [irt_pkg::S_DATA_W-1:0]  s_tdata,
    // op
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_value, entry_count, overflow
    output logic [irt_pkg::M_DATA_W-1:0]  m_tdata
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_READ   = 8'b0000_0010,
        S_EVAL   = 8'b0000_0100,
        S_INS_B  = 8'b0000_1000,
        S_INS_E  = 8'b0001_0000,
        S_COPY   = 8'b0010_0000,
        S_FINISH = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [irt_pkg::VAL_W-1:0]       default_reg;
    logic                            bank_reg, bank_next;
    logic [irt_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [irt_pkg::COUNT_W-1:0]     scan_reg, scan_next;
    logic [irt_pkg::FILL_W-1:0]      fill_reg, fill_next;
    irt_pkg::op_t                    op_reg, op_next;
    logic [irt_pkg::KEY_W-1:0]       key_b_reg, key_b_next;
    logic [irt_pkg::KEY_W-1:0]       key_e_reg, key_e_next;
    logic [irt_pkg::VAL_W-1:0]       val_reg, val_next;
    logic [irt_pkg::VAL_W-1:0]       before_reg, before_next;
    logic [irt_pkg::VAL_W-1:0]       at_end_reg, at_end_next;
    logic                            inserted_reg, inserted_next;
    logic                            ended_reg, ended_next;
    logic                            ovf_reg, ovf_next;
    logic                            m_valid_reg, m_valid_next;
    logic [irt_pkg::M_DATA_W-1:0]    m_data_reg, m_data_next;
    irt_pkg::entry_t                 rd_data_reg;

    irt_pkg::entry_t                 mem [2**irt_pkg::MEM_AW];

    logic                            rd_en;
    logic [irt_pkg::MEM_AW-1:0]      rd_addr;
    logic                            wr_en;
    logic [irt_pkg::MEM_AW-1:0]      wr_addr;
    irt_pkg::entry_t                 wr_data;

    logic [irt_pkg::KEY_W-1:0]       s_kb, s_ke, s_pk;
    logic [irt_pkg::VAL_W-1:0]       s_nv;
    irt_pkg::op_t                    s_op;
    logic                            lt_b, le_e, room;
    logic [irt_pkg::VAL_W-1:0]       read_value;

    assign s_kb = s_tdata[irt_pkg::KB_LSB +: irt_pkg::KEY_W];
    assign s_ke = s_tdata[irt_pkg::KE_LSB +: irt_pkg::KEY_W];
    assign s_nv = s_tdata[irt_pkg::NV_LSB +: irt_pkg::VAL_W];
    assign s_pk = s_tdata[irt_pkg::PK_LSB +: irt_pkg::KEY_W];
    assign s_op = irt_pkg::op_t'(s_tuser[0]);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign lt_b = (rd_data_reg.key < key_b_reg);
    assign le_e = (rd_data_reg.key <= key_e_reg);
    assign room = (fill_reg < irt_pkg::FILL_W'(irt_pkg::DEPTH));

    assign rd_addr = {bank_reg, scan_reg[irt_pkg::IDX_W-1:0]};
    assign wr_addr = {~bank_reg, fill_reg[irt_pkg::IDX_W-1:0]};

    assign read_value = (op_reg == irt_pkg::OP_LOOKUP) ? at_end_reg : '0;

    always_comb begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        fill_next     = fill_reg;
        op_next       = op_reg;
        key_b_next    = key_b_reg;
        key_e_next    = key_e_reg;
        val_next      = val_reg;
        before_next   = before_reg;
        at_end_next   = at_end_reg;
        inserted_next = inserted_reg;
        ended_next    = ended_reg;
        ovf_next      = ovf_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_data       = rd_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next       = s_op;
                    key_b_next    = s_kb;
                    key_e_next    = (s_op == irt_pkg::OP_LOOKUP) ? s_pk : s_ke;
                    val_next      = s_nv;
                    before_next   = default_reg;
                    at_end_next   = default_reg;
                    scan_next     = '0;
                    fill_next     = '0;
                    inserted_next = 1'b0;
                    ended_next    = 1'b0;
                    ovf_next      = 1'b0;
                    if (s_op == irt_pkg::OP_ASSIGN && !(s_kb < s_ke)) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                if (scan_reg == count_reg) begin
                    ended_next = 1'b1;
                    if (op_reg == irt_pkg::OP_LOOKUP) begin
                        state_next = S_OUT;
                    end else if (inserted_reg) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_INS_B;
                    end
                end else begin
                    rd_en      = 1'b1;
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_READ;
                if (le_e) begin
                    at_end_next = rd_data_reg.value;
                end
                if (op_reg == irt_pkg::OP_ASSIGN) begin
                    if (lt_b) begin
                        wr_en       = room;
                        fill_next   = fill_reg + 1'b1;
                        before_next = rd_data_reg.value;
                    end else if (!le_e) begin
                        if (inserted_reg) begin
                            wr_en     = room;
                            fill_next = fill_reg + 1'b1;
                        end else begin
                            state_next = S_INS_B;
                        end
                    end
                end
            end
            S_INS_B: begin
                if (val_reg != before_reg) begin
                    wr_en     = room;
                    wr_data   = '{key: key_b_reg, value: val_reg};
                    fill_next = fill_reg + 1'b1;
                end
                state_next = S_INS_E;
            end
            S_INS_E: begin
                if (at_end_reg != val_reg) begin
                    wr_en     = room;
                    wr_data   = '{key: key_e_reg, value: at_end_reg};
                    fill_next = fill_reg + 1'b1;
                end
                inserted_next = 1'b1;
                state_next    = ended_reg ? S_FINISH : S_COPY;
            end
            S_COPY: begin
                wr_en      = room;
                fill_next  = fill_reg + 1'b1;
                state_next = S_READ;
            end
            S_FINISH: begin
                if (fill_reg > irt_pkg::FILL_W'(irt_pkg::DEPTH)) begin
                    ovf_next = 1'b1;
                end else begin
                    bank_next  = ~bank_reg;
                    count_next = fill_reg[irt_pkg::COUNT_W-1:0];
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = irt_pkg::M_DATA_W'({ovf_reg, count_reg, read_value});
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            default_reg <= '0;
            bank_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                default_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg     <= scan_next;
        fill_reg     <= fill_next;
        op_reg       <= op_next;
        key_b_reg    <= key_b_next;
        key_e_reg    <= key_e_next;
        val_reg      <= val_next;
        before_reg   <= before_next;
        at_end_reg   <= at_end_next;
        inserted_reg <= inserted_next;
        ended_reg    <= ended_next;
        ovf_reg      <= ovf_next;
        m_data_reg   <= m_data_next;
    end

    // table memory, current bank read while the rebuilt table fills the other
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/irt_checker.sv
// port checker for the interval range table, bound to the top level
`include "assert_macros.svh"

module irt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [irt_pkg::M_DATA_W-1:0]  m_tdata
);

    `ASSERT_CLK(a_stall_holds_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `ASSERT_CLK(a_stall_holds_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata))
    `ASSERT_CLK(a_count_in_range, aclk, aresetn, m_tvalid |-> m_tdata[irt_pkg::CNT_LSB +: irt_pkg::COUNT_W] <= irt_pkg::COUNT_W'(irt_pkg::DEPTH))
    `ASSERT_CLK(a_overflow_when_full, aclk, aresetn, m_tvalid && m_tdata[irt_pkg::OVF_BIT] |-> m_tdata[irt_pkg::CNT_LSB +: irt_pkg::COUNT_W] >= irt_pkg::COUNT_W'(irt_pkg::DEPTH - 1))
    `ASSERT_CLK_NR(a_reset_drops_response, aclk, $past(!aresetn) |-> !m_tvalid)

endmodule

bind interval_range_table_unit irt_checker u_irt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
